// ===== hdl/ntps_pkg.sv =====
// Shared types, widths and constants of the nearest-target steering unit.
// Used by every module of the block; depends on nothing.
package ntps_pkg;

  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned ANG_IN_W   = 23;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned LIN_W      = 21;
  localparam int unsigned TURN_W     = 28;
  localparam int unsigned ANG_W      = 25;
  localparam int unsigned CQ_W       = 34;
  localparam int unsigned COS_W      = 32;
  localparam int unsigned MUL_A_W    = 37;
  localparam int unsigned MUL_B_W    = 17;
  localparam int unsigned PROD_W     = 54;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam int unsigned Z_SHIFT    = 10;
  localparam int unsigned OUT_DATA_W = ((LIN_W + TURN_W + 7) / 8) * 8;

  localparam int unsigned MAX_BEAMS_DEF    = 1024;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Angles in 2^-20 rad.
  localparam logic signed [ANG_W-1:0] ANG_PI      = 25'sd3294199;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 25'sd6588397;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 25'sd1647099;
  localparam logic signed [ANG_W-1:0] ANG_LIMIT   = 25'sd8388608;

  // CORDIC start value 0.60725... in Q2.30.
  localparam logic signed [CQ_W-1:0] CORDIC_K = 34'sd652032874;

  localparam logic signed [LIN_W-1:0]  LIN_LIMIT  = 21'sd1048575;
  localparam logic signed [TURN_W-1:0] TURN_LIMIT = 28'sd134217727;

  localparam logic [GAIN_W-1:0]            GAIN_RST  = 16'd4096;
  localparam logic [RANGE_W-1:0]           STOP_RST  = 16'd10;
  localparam logic signed [ANG_IN_W-1:0]   START_RST = -23'sd3294199;
  localparam logic [STEP_W-1:0]            STEP_RST  = 16'd6588;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN  = 2'd0,
    REG_STOP  = 2'd1,
    REG_START = 2'd2,
    REG_STEP  = 2'd3
  } cfg_reg_e;

  // Handshake between the sequencer and the CORDIC unit.
  typedef struct packed {
    logic start;
  } cordic_req_t;

  typedef struct packed {
    logic done;
  } cordic_rsp_t;

  // atan(2^-k) in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:    v = 32'd843314857;
      5'd1:    v = 32'd497837830;
      5'd2:    v = 32'd263043837;
      5'd3:    v = 32'd133525159;
      5'd4:    v = 32'd67021687;
      5'd5:    v = 32'd33543516;
      5'd6:    v = 32'd16775851;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194283;
      5'd9:    v = 32'd2097149;
      5'd10:   v = 32'd1048576;
      5'd11:   v = 32'd524288;
      5'd12:   v = 32'd262144;
      5'd13:   v = 32'd131072;
      5'd14:   v = 32'd65536;
      5'd15:   v = 32'd32768;
      5'd16:   v = 32'd16384;
      5'd17:   v = 32'd8192;
      5'd18:   v = 32'd4096;
      5'd19:   v = 32'd2048;
      5'd20:   v = 32'd1024;
      5'd21:   v = 32'd512;
      5'd22:   v = 32'd256;
      5'd23:   v = 32'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/nearest_target_p_steering_unit.sv =====
// Top level of the nearest-target steering unit: stream ports, registers and the sequencer.
// Depends on ntps_pkg, ntps_track, ntps_mul and ntps_cordic.

// Range samples stream in on the slave side, one beam per cycle while tready is high;
// a beam that is not the last of its scan leaves s_axis_tready high. The beam marked tlast
// closes the scan: the sequencer then forms the beam angle, folds it, runs CORDIC_STEPS
// cosine rotations in the one-rotation-per-cycle CORDIC loop and four products through one
// shared multiplier, with s_axis_tready low until it is done (when the nearest range is at or
// below the stop threshold it forms only the angle product and skips the rest), and longer
// while the output register still holds a result that has not been taken. One result per
// scan leaves through an output register; tuser is high when the unit commands a stop,
// and both speeds are then zero. Configuration writes are always taken and should only
// be issued while no scan is being finished.
module nearest_target_p_steering_unit #(
  parameter int unsigned MAX_BEAMS    = ntps_pkg::MAX_BEAMS_DEF,
  parameter int unsigned CORDIC_STEPS = ntps_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave stream; tdata: range_sample[15:0]. tlast: scan_end.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ntps_pkg::RANGE_W-1:0]        s_axis_tdata,
  input  logic                                s_axis_tlast,
  // Master stream; tdata: linear_speed[20:0], turn_rate[48:21], zero fill[55:49].
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ntps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser: stopped.
  output logic                                m_axis_tuser,
  // Register write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ntps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ntps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ntps_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_BEAMS);
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned FOLD_W  = ANG_W + 1;
  localparam int unsigned LIN_LSB = 18;
  localparam int unsigned T1_LSB  = 12;
  localparam int unsigned TRN_LSB = 12;
  localparam int unsigned PAD_W   = OUT_DATA_W - LIN_W - TURN_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ANGLE = 11'b00000000010,
    S_CLAMP = 11'b00000000100,
    S_FOLD  = 11'b00000001000,
    S_QUAD  = 11'b00000010000,
    S_ROT   = 11'b00000100000,
    S_COS   = 11'b00001000000,
    S_LIN1  = 11'b00010000000,
    S_LIN2  = 11'b00100000000,
    S_TURN  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  localparam logic signed [SUM_W-1:0]  SUM_LIMIT = SUM_W'(ANG_LIMIT);
  localparam logic signed [FOLD_W-1:0] PI_X      = FOLD_W'(ANG_PI);
  localparam logic signed [FOLD_W-1:0] TWO_PI_X  = FOLD_W'(ANG_TWO_PI);

  state_e state_q, state_d;

  // Configuration registers.
  logic [GAIN_W-1:0]          gain_q;
  logic [RANGE_W-1:0]         thresh_q;
  logic signed [ANG_IN_W-1:0] start_q;
  logic [STEP_W-1:0]          step_q;

  // Scan summary and intermediate results.
  logic [RANGE_W-1:0]       scan_range_q;
  logic [IDX_W-1:0]         scan_index_q;
  logic                     stop_q;
  logic signed [ANG_W-1:0]  ang_q, ang_d;
  logic signed [ANG_W-1:0]  fold_q, fold_d;
  logic                     neg_q, neg_d;
  logic signed [COS_W-1:0]  cos_q;
  logic signed [LIN_W-1:0]  lin_q, lin_d;
  logic signed [TURN_W-1:0] turn_d;

  logic [RANGE_W-1:0] trk_range;
  logic [IDX_W-1:0]   trk_index;
  logic               in_xfer;
  logic               stop_d;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  cordic_req_t            cord_req;
  cordic_rsp_t            cord_rsp;
  logic signed [CQ_W-1:0] cord_z0, cord_x;

  logic signed [SUM_W-1:0]  ang_sum;
  logic signed [FOLD_W-1:0] fold_tmp;
  logic signed [ANG_W-1:0]  abs_a, quad_a;
  logic signed [PROD_W-LIN_LSB-1:0] lin_raw;
  logic signed [PROD_W-TRN_LSB-1:0] turn_raw;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_user_q;
  logic                  out_free;
  logic                  out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  ntps_track #(
    .MAX_BEAMS(MAX_BEAMS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .last_i      (s_axis_tlast),
    .range_i     (s_axis_tdata),
    .best_range_o(trk_range),
    .best_index_o(trk_index)
  );

  ntps_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  ntps_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cord_req),
    .z0_i  (cord_z0),
    .rsp_o (cord_rsp),
    .x_o   (cord_x)
  );

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RST;
      thresh_q <= STOP_RST;
      start_q  <= START_RST;
      step_q   <= STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GAIN:  gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_STOP:  thresh_q <= cfg_data_i[RANGE_W-1:0];
        REG_START: start_q  <= cfg_data_i[ANG_IN_W-1:0];
        REG_STEP:  step_q   <= cfg_data_i[STEP_W-1:0];
      endcase
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_ANGLE: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(scan_index_q);
        mul_b  = MUL_B_W'(step_q);
      end
      S_LIN1: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(cos_q);
        mul_b  = MUL_B_W'(scan_range_q);
      end
      S_LIN2: begin
        mul_en = 1'b1;
        mul_a  = prod[MUL_A_W+T1_LSB-1:T1_LSB];
        mul_b  = MUL_B_W'(gain_q);
      end
      S_TURN: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(ang_q);
        mul_b  = MUL_B_W'(gain_q);
      end
      default: begin
      end
    endcase
  end

  // Beam angle with saturation to +/-8 rad, and the stop decision.
  always_comb begin
    ang_sum = SUM_W'(start_q) + SUM_W'(prod[SUM_W-2:0]);
    if (ang_sum > SUM_LIMIT) begin
      ang_d = ANG_LIMIT;
    end else if (ang_sum < -SUM_LIMIT) begin
      ang_d = -ANG_LIMIT;
    end else begin
      ang_d = ang_sum[ANG_W-1:0];
    end
    stop_d = (scan_range_q <= thresh_q);
  end

  // Fold into [-pi, pi]; three passes cover the whole saturated range.
  always_comb begin
    fold_tmp = FOLD_W'(ang_q);
    for (int i = 0; i < 3; i++) begin
      if (fold_tmp > PI_X) begin
        fold_tmp = fold_tmp - TWO_PI_X;
      end else if (fold_tmp < -PI_X) begin
        fold_tmp = fold_tmp + TWO_PI_X;
      end
    end
    fold_d = fold_tmp[ANG_W-1:0];
  end

  // Reflect into [0, pi/2]; the cosine changes sign when the angle lies past pi/2.
  always_comb begin
    abs_a = (fold_q < 0) ? -fold_q : fold_q;
    neg_d = 1'b0;
    quad_a = abs_a;
    if (abs_a > ANG_HALF_PI) begin
      quad_a = ANG_PI - abs_a;
      neg_d  = 1'b1;
    end
    cord_z0        = CQ_W'(quad_a) <<< Z_SHIFT;
    cord_req.start = (state_q == S_QUAD);
  end

  // Saturation of the two commands.
  always_comb begin
    lin_raw  = prod[PROD_W-1:LIN_LSB];
    turn_raw = prod[PROD_W-1:TRN_LSB];
    if (lin_raw > (PROD_W-LIN_LSB)'(LIN_LIMIT)) begin
      lin_d = LIN_LIMIT;
    end else if (lin_raw < -(PROD_W-LIN_LSB)'(LIN_LIMIT)) begin
      lin_d = -LIN_LIMIT;
    end else begin
      lin_d = lin_raw[LIN_W-1:0];
    end
    if (turn_raw > (PROD_W-TRN_LSB)'(TURN_LIMIT)) begin
      turn_d = TURN_LIMIT;
    end else if (turn_raw < -(PROD_W-TRN_LSB)'(TURN_LIMIT)) begin
      turn_d = -TURN_LIMIT;
    end else begin
      turn_d = turn_raw[TURN_W-1:0];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == S_DONE) && out_free;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_xfer && s_axis_tlast) state_d = S_ANGLE;
      S_ANGLE: state_d = S_CLAMP;
      S_CLAMP: state_d = stop_d ? S_DONE : S_FOLD;
      S_FOLD:  state_d = S_QUAD;
      S_QUAD:  state_d = S_ROT;
      S_ROT:   if (cord_rsp.done) state_d = S_COS;
      S_COS:   state_d = S_LIN1;
      S_LIN1:  state_d = S_LIN2;
      S_LIN2:  state_d = S_TURN;
      S_TURN:  state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast) begin
      scan_range_q <= trk_range;
      scan_index_q <= trk_index;
    end
    if (state_q == S_CLAMP) begin
      ang_q  <= ang_d;
      stop_q <= stop_d;
    end
    if (state_q == S_FOLD) begin
      fold_q <= fold_d;
    end
    if (state_q == S_QUAD) begin
      neg_q <= neg_d;
    end
    if (state_q == S_COS) begin
      cos_q <= neg_q ? COS_W'(-cord_x) : COS_W'(cord_x);
    end
    if (state_q == S_TURN) begin
      lin_q <= lin_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_user_q <= stop_q;
      if (stop_q) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {{PAD_W{1'b0}}, turn_d, lin_q};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // A CORDIC result only arrives while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_rsp.done |-> (state_q == S_ROT))
    else $error("CORDIC finished outside the rotation state");

  // A stop result carries zero speeds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("stop result with nonzero speed");

  // A new result only appears after the sequencer finished a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result presented without a finished scan");

endmodule

// ===== hdl/ntps_track.sv =====
// Running minimum of the range samples of one scan and the beam index where it occurs.
// Depends on ntps_pkg.
module ntps_track #(
  parameter int unsigned MAX_BEAMS = ntps_pkg::MAX_BEAMS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_BEAMS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         last_i,
  input  logic [ntps_pkg::RANGE_W-1:0] range_i,
  output logic [ntps_pkg::RANGE_W-1:0] best_range_o,
  output logic [IDX_W-1:0]             best_index_o
);
  import ntps_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BEAMS + 1);

  logic [RANGE_W-1:0] best_range_q, best_range_d;
  logic [IDX_W-1:0]   best_index_q, best_index_d;
  logic [CNT_W-1:0]   count_q, count_d;

  always_comb begin
    best_range_d = best_range_q;
    best_index_d = best_index_q;
    count_d      = count_q;
    // Beams past the limit are ignored; an equal range keeps the earlier beam.
    if (count_q < CNT_W'(MAX_BEAMS)) begin
      if (range_i < best_range_q) begin
        best_range_d = range_i;
        best_index_d = count_q[IDX_W-1:0];
      end
      count_d = count_q + CNT_W'(1);
    end
  end

  assign best_range_o = best_range_d;
  assign best_index_o = best_index_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_range_q <= '1;
      best_index_q <= '0;
      count_q      <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        best_range_q <= '1;
        best_index_q <= '0;
        count_q      <= '0;
      end else begin
        best_range_q <= best_range_d;
        best_index_q <= best_index_d;
        count_q      <= count_d;
      end
    end
  end

endmodule

// ===== hdl/ntps_mul.sv =====
// Shared signed multiplier with a registered product, used for every product of a scan.
// Depends on ntps_pkg.
module ntps_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [ntps_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [ntps_pkg::MUL_B_W-1:0] b_i,
  output logic signed [ntps_pkg::PROD_W-1:0]  prod_o
);
  import ntps_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/ntps_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, x gives the cosine in Q2.30.
// Depends on ntps_pkg.
module ntps_cordic #(
  parameter int unsigned CORDIC_STEPS = ntps_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ntps_pkg::cordic_req_t            req_i,
  input  logic signed [ntps_pkg::CQ_W-1:0] z0_i,
  output ntps_pkg::cordic_rsp_t            rsp_o,
  output logic signed [ntps_pkg::CQ_W-1:0] x_o
);
  import ntps_pkg::*;

  localparam int unsigned K_W = $clog2(CORDIC_STEPS);

  logic signed [CQ_W-1:0] x_q, y_q, z_q;
  logic signed [CQ_W-1:0] dx, dy, at;
  logic [K_W-1:0]         k_q;
  logic                   run_q, done_q;
  logic                   last_step;

  assign dx        = y_q >>> k_q;
  assign dy        = x_q >>> k_q;
  assign at        = CQ_W'(atan_q30(ATAN_IDX_W'(k_q)));
  assign last_step = (k_q == K_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        k_q   <= '0;
      end else if (run_q) begin
        k_q <= k_q + K_W'(1);
        if (last_step) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= CORDIC_K;
      y_q <= '0;
      z_q <= z0_i;
    end else if (run_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign x_o        = x_q;

endmodule

// ===== test/nearest_target_p_steering_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the nearest-target steering unit: range scans in, steering commands out.
// Depends on ntps_pkg and nearest_target_p_steering_unit; everything else is local.

typedef struct {
  longint lin;
  longint turn;
  bit     stopped;
} steer_cmd_t;

// Tracks the nearest beam of each scan and predicts the command that closes it.
class steering_scoreboard;
  localparam int     SCAN_BEAMS = 1024;
  localparam int     ROTATIONS  = 16;
  localparam longint PI_A       = 3294199;
  localparam longint TWO_PI_A   = 6588397;
  localparam longint HALF_PI_A  = 1647099;
  localparam longint ANG_SAT    = 8388608;
  localparam longint K_Q30      = 652032874;
  localparam longint LIN_SAT    = 1048575;
  localparam longint TURN_SAT   = 134217727;

  longint     gain;
  longint     stop_thr;
  longint     start_ang;
  longint     step;
  longint     best_range;
  longint     best_index;
  longint     beam_count;
  longint     atan_tbl[24];
  steer_cmd_t cmds_due[$];
  int         errors;
  int         scans;
  int         stops;
  int         results;

  function new();
    atan_tbl = '{843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
                 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                 262144, 131072, 65536, 32768, 16384, 8192,
                 4096, 2048, 1024, 512, 256, 128};
    gain      = 4096;
    stop_thr  = 10;
    start_ang = -3294199;
    step      = 6588;
    errors    = 0;
    scans     = 0;
    stops     = 0;
    results   = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    best_range = 65535;
    best_index = 0;
    beam_count = 0;
  endfunction

  function longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function int pending();
    return cmds_due.size();
  endfunction

  function void write_reg(ntps_pkg::cfg_reg_e idx, logic [31:0] data);
    case (idx)
      ntps_pkg::REG_GAIN:  gain = longint'(data[15:0]);
      ntps_pkg::REG_STOP:  stop_thr = longint'(data[15:0]);
      ntps_pkg::REG_START: start_ang = longint'($signed(data[22:0]));
      ntps_pkg::REG_STEP:  step = longint'(data[15:0]);
      default: ;
    endcase
  endfunction

  function void note_beam(logic [15:0] r, logic last);
    longint     ang;
    longint     a;
    longint     x;
    longint     y;
    longint     z;
    longint     dx;
    longint     dy;
    longint     t;
    bit         neg;
    steer_cmd_t cmd;
    // Beams past the end of the tracking window are counted out but never compared.
    if (beam_count < SCAN_BEAMS) begin
      if (longint'(r) < best_range) begin
        best_range = longint'(r);
        best_index = beam_count;
      end
      beam_count++;
    end
    if (!last) return;
    ang = sat(start_ang + best_index * step, ANG_SAT);
    cmd.stopped = (best_range <= stop_thr);
    cmd.lin = 0;
    cmd.turn = 0;
    if (!cmd.stopped) begin
      // Fold into [-pi, pi], then into [0, pi/2] with the sign of the cosine kept aside.
      a = ang;
      for (int k = 0; k < 3; k++) begin
        if (a > PI_A) a -= TWO_PI_A;
        else if (a < -PI_A) a += TWO_PI_A;
      end
      if (a < 0) a = -a;
      neg = 0;
      if (a > HALF_PI_A) begin
        a = PI_A - a;
        neg = 1;
      end
      x = K_Q30;
      y = 0;
      z = a * 1024;
      for (int k = 0; k < ROTATIONS; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= atan_tbl[k];
        end else begin
          x += dx;
          y -= dy;
          z += atan_tbl[k];
        end
      end
      if (neg) x = -x;
      t = ((best_range * x) >>> 12) * gain;
      cmd.lin = sat(t >>> 18, LIN_SAT);
      cmd.turn = sat((ang * gain) >>> 12, TURN_SAT);
    end
    if (cmd.stopped) stops++;
    scans++;
    cmds_due.push_back(cmd);
    clear_scan();
  endfunction

  function void check_result(logic [20:0] lin, logic [27:0] turn, logic [6:0] fill,
                             logic stopped);
    steer_cmd_t want;
    results++;
    if (cmds_due.size() == 0) begin
      $error("command with no scan closed: linear_speed %0d turn_rate %0d stopped %0b",
             $signed(lin), $signed(turn), stopped);
      errors++;
      return;
    end
    want = cmds_due.pop_front();
    if (lin !== want.lin[20:0]) begin
      $error("linear_speed: expected %0d, got %0d", want.lin, $signed(lin));
      errors++;
    end
    if (turn !== want.turn[27:0]) begin
      $error("turn_rate: expected %0d, got %0d", want.turn, $signed(turn));
      errors++;
    end
    if (stopped !== want.stopped) begin
      $error("stopped: expected %0b, got %0b", want.stopped, stopped);
      errors++;
    end
    if (fill !== '0) begin
      $error("tdata fill: expected 0, got %0h", fill);
      errors++;
    end
  endfunction
endclass

module nearest_target_p_steering_unit_tb;
  import ntps_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_BEAMS   = 45;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_valid;
  logic                  s_axis_tready;
  logic [RANGE_W-1:0]    s_data;
  logic                  s_last;
  logic                  m_axis_tvalid;
  logic                  m_ready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  steering_scoreboard sb;
  bit                 src_idle_on;
  bit                 snk_idle_on;
  bit                 pressure_on;
  int                 beams;
  int                 reg_writes;
  int                 settings;
  int                 cycle_cnt;

  nearest_target_p_steering_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off that lets the block fill up.
  initial begin
    int  hold_left;
    bit  pressure_done;
    m_ready = 1'b0;
    hold_left = 0;
    pressure_done = 0;
    forever begin
      @(negedge clk_i);
      if (pressure_on && !pressure_done) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1;
      end
      if (hold_left > 0) begin
        m_ready = 1'b0;
        hold_left--;
      end else begin
        m_ready = !(snk_idle_on && $urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      sb.check_result(m_axis_tdata[20:0], m_axis_tdata[48:21], m_axis_tdata[55:49],
                      m_axis_tuser);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_beam(input logic [RANGE_W-1:0] r, input logic last);
    if (src_idle_on && $urandom_range(99) < 10) begin
      s_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data = r;
    s_last = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_beam(r, last);
    beams++;
    @(negedge clk_i);
  endtask

  task automatic send_scan(input int n);
    logic [RANGE_W-1:0] r;
    logic [RANGE_W-1:0] prev;
    longint             near;
    prev = RANGE_W'($urandom);
    near = sb.stop_thr * 2 + 16;
    if (near > 65535) near = 65535;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0:          r = '1;
        1:          r = '0;
        2, 3:       r = prev;  // equal ranges must keep the first beam
        4, 5, 6, 7: r = RANGE_W'($urandom_range(0, int'(near)));
        default:    r = RANGE_W'($urandom);
      endcase
      send_beam(r, i == n - 1);
      prev = r;
    end
  endtask

  // Waits until every command has come out and the block has had time to go quiet.
  task automatic drain();
    s_valid = 1'b0;
    s_last = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input int g, input int thr, input int st, input int stp);
    drain();
    write_reg(REG_GAIN, g);
    write_reg(REG_STOP, thr);
    write_reg(REG_START, st);
    write_reg(REG_STEP, stp);
    settings++;
  endtask

  initial begin
    int first;
    sb = new();
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_data = '0;
    s_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GAIN;
    cfg_data = '0;
    src_idle_on = 1;
    snk_idle_on = 1;
    pressure_on = 0;
    beams = 0;
    reg_writes = 0;
    settings = 1;
    cycle_cnt = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed scans with the reset settings: stop edges, all-far scan, ties.
    send_beam(16'd0, 1'b1);
    send_beam(16'd10, 1'b1);
    send_beam(16'd11, 1'b1);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'hFFFF, 1'b1);
    send_beam(16'd500, 1'b0);
    send_beam(16'd300, 1'b0);
    send_beam(16'd300, 1'b0);
    send_beam(16'd700, 1'b1);
    send_beam(16'd40000, 1'b0);
    send_beam(16'd5555, 1'b0);
    send_beam(16'd5555, 1'b1);

    // Largest gain and step, with the start angle at pi, push the beam angle past pi.
    configure(65535, 0, 3294199, 65535);
    send_beam(16'hFFFF, 1'b1);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'd50000, 1'b0);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'd1, 1'b1);
    send_beam(16'd0, 1'b1);
    send_beam(16'hAAAA, 1'b0);
    send_beam(16'h5555, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(65535, 0, -3294199, 0);
        1: configure(0, 65535, 3294199, 65535);
        2: configure(4096, 50, -3294199, 6588);
        default: configure($urandom_range(0, 65535), $urandom_range(0, 3000),
                           int'($urandom_range(0, 6588398)) - 3294199,
                           $urandom_range(0, 65535));
      endcase
      src_idle_on = (p != 5);
      snk_idle_on = (p != 5);
      if (p == 3) pressure_on = 1;
      if (p == 2) begin
        // Overlong scan: ranges fall to the end of the window, and the closer beams after it
        // must be ignored.
        for (int i = 0; i < 1030; i++) begin
          send_beam((i < 1024) ? 16'(60000 - 50 * i) : 16'd0, i == 1029);
        end
      end
      first = beams;
      while (beams - first < PHASE_BEAMS) begin
        send_scan(($urandom_range(7) == 0) ? 1 : $urandom_range(2, 16));
      end
    end

    drain();
    $display("Sent %0d beams in %0d scans under %0d register settings (%0d writes).",
             beams, sb.scans, settings, reg_writes);
    $display("Checked %0d steering commands, %0d of them stops.", sb.results, sb.stops);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== nearest_target_p_steering_unit.f =====
hdl/ntps_pkg.sv
hdl/ntps_track.sv
hdl/ntps_mul.sv
hdl/ntps_cordic.sv
hdl/nearest_target_p_steering_unit.sv
test/nearest_target_p_steering_unit_tb.sv
